[design/u8ss_pkg.sv]
// Shared constants and types for the UTF-8 stream sanitizer.
package u8ss_pkg;

    // Byte classes
    localparam logic [7:0] ContMask   = 8'hC0;
    localparam logic [7:0] ContCode   = 8'h80;
    localparam logic [7:0] Lead2Mask  = 8'hE0;
    localparam logic [7:0] Lead2Code  = 8'hC0;
    localparam logic [7:0] Lead3Mask  = 8'hF0;
    localparam logic [7:0] Lead3Code  = 8'hE0;
    localparam logic [7:0] NulByte    = 8'h00;

    // Sequence lengths held in expected_length
    localparam logic [1:0] LenNone    = 2'd0;
    localparam logic [1:0] LenTwo     = 2'd2;
    localparam logic [1:0] LenThree   = 2'd3;

    // Output queue geometry
    localparam int MaxResults = 3;
    localparam int FifoDepth  = 8;
    localparam int PtrW       = $clog2(FifoDepth);
    localparam int CntW       = $clog2(FifoDepth + 1);
    localparam int PushW      = $clog2(MaxResults + 1);

    // One queued output word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } u8ss_word_t;

endpackage

[design/u8ss_fifo.sv]
// Output queue: takes up to three words per cycle, hands out one per cycle while out_ready is high.
module u8ss_fifo
    import u8ss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PushW-1:0]     push_count,
    input  u8ss_word_t           push_words [MaxResults],
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output u8ss_word_t           head_word
);

    u8ss_word_t       mem_reg [FifoDepth];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_next;
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic             pop;

    // Accept a new input only when a full burst fits
    assign room      = (count_reg <= CntW'(FifoDepth - MaxResults));
    assign out_valid = (count_reg != '0);
    assign head_word = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = PtrW'(wr_ptr_reg + PtrW'(push_count));
        rd_ptr_next = pop ? PtrW'(rd_ptr_reg + PtrW'(1)) : rd_ptr_reg;
        count_next  = CntW'(count_reg + CntW'(push_count) - CntW'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the pushed words at consecutive slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MaxResults; i++)
        begin
            if (PushW'(i) < push_count)
            begin
                mem_reg[PtrW'(wr_ptr_reg + PtrW'(i))] <= push_words[i];
            end
        end
    end

endmodule

[design/utf8_stream_sanitizer.sv]
// Top level of the UTF-8 stream sanitizer: byte classifier, pending sequence and output queue.
// A kept byte is written into the output queue registers when the word that completes it is accepted.
// Throughput: one input word per cycle while in_ready is high; the output drains one word
// per cycle while out_ready is high, from an eight-entry output queue.
// in_ready drops while the queue could not take a full three-word burst.
// Reset clears the pending sequence and empties the queue.
module utf8_stream_sanitizer
    import u8ss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_buffer,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last
);

    logic [7:0]       held_lead_reg;
    logic [7:0]       held_lead_next;
    logic [7:0]       held_second_reg;
    logic [7:0]       held_second_next;
    logic [1:0]       expected_length_reg;
    logic [1:0]       expected_length_next;
    logic [1:0]       bytes_collected_reg;
    logic [1:0]       bytes_collected_next;

    logic             accept;
    logic             pending;
    logic             is_cont;
    logic [PushW-1:0] emit_count;
    logic [PushW-1:0] push_count;
    logic [7:0]       emit_byte [MaxResults];
    u8ss_word_t       push_words [MaxResults];
    logic             room;
    u8ss_word_t       head_word;

    assign in_ready = room;
    assign accept   = in_valid && room;
    assign pending  = (expected_length_reg == LenTwo) || (expected_length_reg == LenThree);
    assign is_cont  = ((in_byte & ContMask) == ContCode);

    // Classify the incoming word and update the pending sequence
    always_comb
    begin
        held_lead_next       = held_lead_reg;
        held_second_next     = held_second_reg;
        expected_length_next = expected_length_reg;
        bytes_collected_next = bytes_collected_reg;
        emit_count           = '0;
        emit_byte[0]         = held_lead_reg;
        emit_byte[1]         = in_byte;
        emit_byte[2]         = in_byte;

        if (pending && is_cont)
        begin
            if (expected_length_reg == LenTwo)
            begin
                emit_count           = PushW'(2);
                held_lead_next       = '0;
                held_second_next     = '0;
                expected_length_next = LenNone;
                bytes_collected_next = 2'd0;
            end
            else if (bytes_collected_reg < 2'd2)
            begin
                held_second_next     = in_byte;
                bytes_collected_next = 2'd2;
            end
            else
            begin
                emit_count           = PushW'(3);
                emit_byte[1]         = held_second_reg;
                held_lead_next       = '0;
                held_second_next     = '0;
                expected_length_next = LenNone;
                bytes_collected_next = 2'd0;
            end
        end
        else
        begin
            // Drop whatever was held, then take the word afresh
            held_lead_next       = '0;
            held_second_next     = '0;
            expected_length_next = LenNone;
            bytes_collected_next = 2'd0;
            if (in_byte < ContCode)
            begin
                if (in_byte != NulByte)
                begin
                    emit_count   = PushW'(1);
                    emit_byte[0] = in_byte;
                end
            end
            else if ((in_byte & Lead2Mask) == Lead2Code)
            begin
                held_lead_next       = in_byte;
                expected_length_next = LenTwo;
                bytes_collected_next = 2'd1;
            end
            else if ((in_byte & Lead3Mask) == Lead3Code)
            begin
                held_lead_next       = in_byte;
                expected_length_next = LenThree;
                bytes_collected_next = 2'd1;
            end
        end

        // Drop a sequence left open at the end of the buffer
        if (end_of_buffer)
        begin
            held_lead_next       = '0;
            held_second_next     = '0;
            expected_length_next = LenNone;
            bytes_collected_next = 2'd0;
        end
    end

    // Build the queued words, marking the final one
    always_comb
    begin
        push_count = accept ? emit_count : '0;
        for (int i = 0; i < MaxResults; i++)
        begin
            push_words[i].data = emit_byte[i];
            push_words[i].last = (PushW'(i + 1) == emit_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_lead_reg       <= '0;
            held_second_reg     <= '0;
            expected_length_reg <= LenNone;
            bytes_collected_reg <= 2'd0;
        end
        else if (accept)
        begin
            held_lead_reg       <= held_lead_next;
            held_second_reg     <= held_second_next;
            expected_length_reg <= expected_length_next;
            bytes_collected_reg <= bytes_collected_next;
        end
    end

    u8ss_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_words (push_words),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .head_word  (head_word)
    );

    assign out_byte = head_word.data;
    assign run_last = head_word.last;

endmodule
